>>> sv/r2k_pkg.sv
// Shared types, constants and lookup functions of the romaji to kana transliterator.
package r2k_pkg;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_FLUSH = 2'd1,
    ACT_BKSP  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_KANA       = 2'd0,
    KIND_RAW        = 2'd1,
    KIND_ERASE_LAST = 2'd2,
    KIND_ERASE_ALL  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RULE,
    ST_EMIT2,
    ST_FLUSH,
    ST_SINGLE
  } state_t;

  localparam logic [15:0] CP_SMALL_TSU = 16'h3063;
  localparam logic [15:0] CP_N         = 16'h3093;
  localparam logic [7:0]  CH_N         = 8'h6E;

  // Result of one rule evaluation over the pending buffer.
  typedef struct packed {
    logic        hit;
    logic [1:0]  kind;
    logic [15:0] k1;
    logic [15:0] k2;
    logic [2:0]  drop;
  } rule_res_t;

  function automatic logic [2:0] vowel_idx(input logic [7:0] c);
    case (c)
      8'h61:   return 3'd0;
      8'h69:   return 3'd1;
      8'h75:   return 3'd2;
      8'h65:   return 3'd3;
      8'h6F:   return 3'd4;
      default: return 3'd7;
    endcase
  endfunction

  function automatic logic [15:0] small_y(input logic [7:0] c);
    case (c)
      8'h61:   return 16'h3083;
      8'h75:   return 16'h3085;
      8'h6F:   return 16'h3087;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic is_yoon_lead(input logic [7:0] c);
    case (c)
      "s", "t", "z", "k", "g", "n", "h", "m", "r", "b", "p": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Consonant row table: letter plus vowel index gives kana, zero for none.
  function automatic logic [15:0] row_kana(input logic [7:0] c, input logic [2:0] v);
    logic [15:0] r0, r1, r2, r3, r4;
    r0 = 16'h0; r1 = 16'h0; r2 = 16'h0; r3 = 16'h0; r4 = 16'h0;
    case (c)
      "b": begin r0=16'h3070; r1=16'h3073; r2=16'h3076; r3=16'h3079; r4=16'h307C; end
      "d": begin r0=16'h3060; r1=16'h3062; r2=16'h3065; r3=16'h3067; r4=16'h3069; end
      "f": begin r2=16'h3075; end
      "g": begin r0=16'h304C; r1=16'h304E; r2=16'h3050; r3=16'h3052; r4=16'h3054; end
      "h": begin r0=16'h306F; r1=16'h3072; r2=16'h3075; r3=16'h3078; r4=16'h307B; end
      "k": begin r0=16'h304B; r1=16'h304D; r2=16'h304F; r3=16'h3051; r4=16'h3053; end
      "l", "x": begin
        r0=16'h3041; r1=16'h3043; r2=16'h3045; r3=16'h3047; r4=16'h3049;
      end
      "m": begin r0=16'h307E; r1=16'h307F; r2=16'h3080; r3=16'h3081; r4=16'h3082; end
      "n": begin r0=16'h306A; r1=16'h306B; r2=16'h306C; r3=16'h306D; r4=16'h306E; end
      "p": begin r0=16'h3071; r1=16'h3074; r2=16'h3077; r3=16'h307A; r4=16'h307D; end
      "r": begin r0=16'h3089; r1=16'h308A; r2=16'h308B; r3=16'h308C; r4=16'h308D; end
      "s": begin r0=16'h3055; r1=16'h3057; r2=16'h3059; r3=16'h305B; r4=16'h305D; end
      "t": begin r0=16'h305F; r1=16'h3061; r2=16'h3064; r3=16'h3066; r4=16'h3068; end
      "w": begin r0=16'h308F; r4=16'h3092; end
      "y": begin r0=16'h3084; r2=16'h3086; r4=16'h3088; end
      "z": begin r0=16'h3056; r1=16'h3058; r2=16'h305A; r3=16'h305C; r4=16'h305E; end
      default: ;
    endcase
    case (v)
      3'd0:    return r0;
      3'd1:    return r1;
      3'd2:    return r2;
      3'd3:    return r3;
      3'd4:    return r4;
      default: return 16'h0;
    endcase
  endfunction

endpackage

>>> sv/r2k_rule_unit.sv
// Rule evaluator, used by the main and the lookahead instance: one pass of the match rules over the pending buffer.
module r2k_rule_unit (
  input  logic [7:0]          c0,
  input  logic [7:0]          c1,
  input  logic [7:0]          c2,
  input  logic [2:0]          count,
  output r2k_pkg::rule_res_t  res
);
  import r2k_pkg::*;

  logic [15:0] sm2, sm1, base, rk2, rk0;
  logic        hit3, hit2, hit1;
  logic [15:0] a1, a2, b1, b2;
  logic        c0_cons;

  always_comb begin
    sm2  = small_y(c2);
    sm1  = small_y(c1);
    base = (c0 == "s") ? 16'h3057 : 16'h3061;
    rk2  = row_kana(c0, vowel_idx(c1));
    rk0  = row_kana(c0, 3'd1);
    c0_cons = (c0 >= "a") && (c0 <= "z") && (vowel_idx(c0) == 3'd7);

    hit3 = 1'b0; a1 = 16'h0; a2 = 16'h0;
    if (c1 == "y" && sm2 != 16'h0) begin
      if (is_yoon_lead(c0)) begin
        hit3 = 1'b1; a1 = rk0; a2 = sm2;
      end else if (c0 == "x" || c0 == "l") begin
        hit3 = 1'b1; a1 = sm2;
      end
    end else if ((c0 == "s" || c0 == "c") && c1 == "h") begin
      if (c2 == "i") begin
        hit3 = 1'b1; a1 = base;
      end else if (sm2 != 16'h0) begin
        hit3 = 1'b1; a1 = base; a2 = sm2;
      end
    end else if (c0 == "t" && c1 == "s" && c2 == "u") begin
      hit3 = 1'b1; a1 = 16'h3064;
    end else if ((c0 == "x" || c0 == "l") && c1 == "t" && c2 == "u") begin
      hit3 = 1'b1; a1 = CP_SMALL_TSU;
    end

    hit2 = 1'b0; b1 = 16'h0; b2 = 16'h0;
    if (c0 == CH_N && (c1 == CH_N || c1 == 8'h27)) begin
      hit2 = 1'b1; b1 = CP_N;
    end else if (c0 == "j") begin
      if (c1 == "i") begin
        hit2 = 1'b1; b1 = 16'h3058;
      end else if (sm1 != 16'h0) begin
        hit2 = 1'b1; b1 = 16'h3058; b2 = sm1;
      end
    end else if (rk2 != 16'h0) begin
      hit2 = 1'b1; b1 = rk2;
    end

    hit1 = (vowel_idx(c0) != 3'd7);

    res = '0;
    res.kind = KIND_KANA;
    if (count >= 3'd3 && hit3) begin
      res.hit = 1'b1; res.k1 = a1; res.k2 = a2; res.drop = 3'd3;
    end else if (count >= 3'd2 && hit2) begin
      res.hit = 1'b1; res.k1 = b1; res.k2 = b2; res.drop = 3'd2;
    end else if (count >= 3'd1 && hit1) begin
      res.hit = 1'b1; res.k1 = 16'h3042 + {12'h0, vowel_idx(c0), 1'b0}; res.drop = 3'd1;
    end else if (count >= 3'd2 && c0 == c1 && c0_cons && c0 != CH_N) begin
      res.hit = 1'b1; res.k1 = CP_SMALL_TSU; res.drop = 3'd1;
    end else if (count >= 3'd2 && c0 == CH_N && vowel_idx(c1) == 3'd7 &&
                 c1 != "y" && c1 != CH_N) begin
      res.hit = 1'b1; res.k1 = CP_N; res.drop = 3'd1;
    end else if (count >= 3'd4) begin
      res.hit = 1'b1; res.kind = KIND_RAW; res.k1 = {8'h0, c0}; res.drop = 3'd1;
    end
  end

endmodule

>>> sv/romaji_to_kana_transliterator.sv
// Top level of the romaji to kana transliterator: buffer, sequencer and output register.
module romaji_to_kana_transliterator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  r2k_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output r2k_pkg::out_item_t  out_data
);
  // One request is taken at a time. The block stalls its input until every
  // result of that request has been loaded into the output register. After
  // the request is taken, the sequencer loads one result per cycle while the
  // output is not stalled or, when the rule unit finds nothing, goes back to
  // idle. A lookahead copy of the rule unit tells whether another rule
  // follows, so the final result is marked without a further check. Flush
  // emits the pending bytes one per cycle while the output is not stalled;
  // a lone pending n is emitted as kana, and an empty flush gives no result.
  // Clear and backspace on an empty buffer pass through the single-result
  // state. Backspace on a nonempty buffer produces no result and leaves the
  // block idle. The "last" flag marks the final result of each request; a
  // request without results gives no output at all. Output stall simply
  // holds the sequencer in place.
  import r2k_pkg::*;

  state_t     state, state_next;
  logic [7:0] buf_q [4];
  logic [2:0] count;
  logic [1:0] fidx;
  logic [15:0] k2_hold;
  rule_res_t  rr, rr_after;
  logic [7:0] sh [4];
  logic [2:0] cnt_after;
  logic       erase_all;

  logic       emit;
  out_item_t  emit_item;
  logic       can_emit;

  assign in_stall = (state != ST_IDLE);
  assign can_emit = !out_valid || !out_stall;

  r2k_rule_unit u_rule (
    .c0(buf_q[0]), .c1(buf_q[1]), .c2(buf_q[2]), .count(count), .res(rr)
  );

  // Buffer after applying the current drop, to tell whether another rule follows.
  always_comb begin
    for (int i = 0; i < 4; i++) sh[i] = 8'h0;
    case (rr.drop)
      3'd1: begin sh[0] = buf_q[1]; sh[1] = buf_q[2]; sh[2] = buf_q[3]; end
      3'd2: begin sh[0] = buf_q[2]; sh[1] = buf_q[3]; end
      3'd3: begin sh[0] = buf_q[3]; end
      default: ;
    endcase
    cnt_after = count - rr.drop;
  end

  r2k_rule_unit u_rule_peek (
    .c0(sh[0]), .c1(sh[1]), .c2(sh[2]), .count(cnt_after), .res(rr_after)
  );

  always_comb begin
    state_next = state;
    emit = 1'b0;
    emit_item = '0;
    case (state)
      ST_RULE: begin
        if (rr.hit && can_emit) begin
          emit = 1'b1;
          emit_item.kind = rr.kind;
          emit_item.code = rr.k1;
          if (rr.k2 != 16'h0) begin
            state_next = ST_EMIT2;
          end else begin
            emit_item.last = !rr_after.hit;
            state_next = rr_after.hit ? ST_RULE : ST_IDLE;
          end
        end else if (!rr.hit) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_item.kind = KIND_KANA;
          emit_item.code = k2_hold;
          emit_item.last = !rr.hit;
          state_next = rr.hit ? ST_RULE : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit = 1'b1;
          if (count == 3'd1 && buf_q[0] == CH_N) begin
            emit_item.kind = KIND_KANA;
            emit_item.code = CP_N;
            emit_item.last = 1'b1;
            state_next = ST_IDLE;
          end else begin
            emit_item.kind = KIND_RAW;
            emit_item.code = {8'h0, buf_q[fidx]};
            emit_item.last = ({1'b0, fidx} == count - 3'd1);
            if (emit_item.last) state_next = ST_IDLE;
          end
        end
      end
      ST_SINGLE: begin
        if (can_emit) begin
          emit = 1'b1;
          emit_item.kind = erase_all ? KIND_ERASE_ALL : KIND_ERASE_LAST;
          emit_item.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        if (in_valid) begin
          case (in_data.action)
            ACT_ADD:   state_next = ST_RULE;
            ACT_FLUSH: state_next = (count == 3'd0) ? ST_IDLE : ST_FLUSH;
            ACT_BKSP:  state_next = (count == 3'd0) ? ST_SINGLE : ST_IDLE;
            default:   state_next = ST_SINGLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= 3'd0;
      out_valid <= 1'b0;
      fidx      <= 2'd0;
      erase_all <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          fidx <= 2'd0;
          if (in_valid) begin
            // Clear and an empty backspace share the single-result state.
            erase_all <= (in_data.action == ACT_CLEAR);
            case (in_data.action)
              ACT_ADD: begin
                if (count < 3'd4) begin
                  buf_q[count[1:0]] <= in_data.ch;
                  count <= count + 3'd1;
                end
              end
              ACT_BKSP:  if (count != 3'd0) count <= count - 3'd1;
              ACT_CLEAR: count <= 3'd0;
              default: ;
            endcase
          end
        end
        ST_RULE: begin
          if (emit) begin
            k2_hold <= rr.k2;
            for (int i = 0; i < 4; i++) buf_q[i] <= sh[i];
            count <= cnt_after;
          end
        end
        ST_FLUSH: begin
          if (emit) begin
            fidx <= fidx + 2'd1;
            if (state_next == ST_IDLE) count <= 3'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= emit_item;
  end

  // The pending buffer never holds more than four characters.
  assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("pending count overflow");
  // Between requests at most three characters remain pending.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state) != ST_IDLE) |-> count <= 3'd3)
    else $error("four characters left pending");
  // A held result is not overwritten while stalled.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");
  // Input is only taken while idle.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");

endmodule

>>> tb/sv/romaji_to_kana_transliterator_tb.sv
// Testbench for the romaji to kana transliterator: stimulus, prediction and result checking.
module romaji_to_kana_transliterator_tb;
  import r2k_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  romaji_to_kana_transliterator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Requests waiting to be driven, and kana results waiting to be seen.
  in_item_t  request_q[$];
  out_item_t kana_q[$];
  bit        failed;
  bit        stim_done;
  int        cycle_cnt;

  // The predictor's own copy of the pending buffer.
  logic [7:0] typed_buf[4];
  int         typed_cnt;
  out_item_t  step_res[$];

  function automatic int vowel_of(logic [7:0] c);
    case (c)
      "a": return 0;
      "i": return 1;
      "u": return 2;
      "e": return 3;
      "o": return 4;
      default: return -1;
    endcase
  endfunction

  function automatic logic [15:0] small_y_of(logic [7:0] c);
    case (c)
      "a": return 16'h3083;
      "u": return 16'h3085;
      "o": return 16'h3087;
      default: return 16'h0;
    endcase
  endfunction

  function automatic logic [15:0] row_of(logic [7:0] c, int v);
    logic [15:0] r[5];
    r = '{default: 16'h0};
    case (c)
      "b": r = '{16'h3070, 16'h3073, 16'h3076, 16'h3079, 16'h307C};
      "d": r = '{16'h3060, 16'h3062, 16'h3065, 16'h3067, 16'h3069};
      "f": r[2] = 16'h3075;
      "g": r = '{16'h304C, 16'h304E, 16'h3050, 16'h3052, 16'h3054};
      "h": r = '{16'h306F, 16'h3072, 16'h3075, 16'h3078, 16'h307B};
      "k": r = '{16'h304B, 16'h304D, 16'h304F, 16'h3051, 16'h3053};
      "l", "x": r = '{16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049};
      "m": r = '{16'h307E, 16'h307F, 16'h3080, 16'h3081, 16'h3082};
      "n": r = '{16'h306A, 16'h306B, 16'h306C, 16'h306D, 16'h306E};
      "p": r = '{16'h3071, 16'h3074, 16'h3077, 16'h307A, 16'h307D};
      "r": r = '{16'h3089, 16'h308A, 16'h308B, 16'h308C, 16'h308D};
      "s": r = '{16'h3055, 16'h3057, 16'h3059, 16'h305B, 16'h305D};
      "t": r = '{16'h305F, 16'h3061, 16'h3064, 16'h3066, 16'h3068};
      "w": begin r[0] = 16'h308F; r[4] = 16'h3092; end
      "y": begin r[0] = 16'h3084; r[2] = 16'h3086; r[4] = 16'h3088; end
      "z": r = '{16'h3056, 16'h3058, 16'h305A, 16'h305C, 16'h305E};
      default: ;
    endcase
    if (v < 0) return 16'h0;
    return r[v];
  endfunction

  function automatic bit yoon_lead(logic [7:0] c);
    case (c)
      "s", "t", "z", "k", "g", "n", "h", "m", "r", "b", "p": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_cons(logic [7:0] c);
    return c >= "a" && c <= "z" && vowel_of(c) < 0;
  endfunction

  // Table lookup over the first len pending letters; the caller tries the longest first.
  function automatic bit match_kana(int len, output logic [15:0] k1, output logic [15:0] k2);
    logic [7:0]  c0, c1, c2;
    logic [15:0] sm;
    logic [15:0] base;
    c0 = typed_buf[0]; c1 = typed_buf[1]; c2 = typed_buf[2];
    k1 = 16'h0; k2 = 16'h0;
    if (len == 3) begin
      sm = small_y_of(c2);
      if (c1 == "y" && sm != 0) begin
        if (yoon_lead(c0)) begin k1 = row_of(c0, 1); k2 = sm; return 1; end
        if (c0 == "x" || c0 == "l") begin k1 = sm; return 1; end
        return 0;
      end
      if ((c0 == "s" || c0 == "c") && c1 == "h") begin
        base = (c0 == "s") ? 16'h3057 : 16'h3061;
        if (c2 == "i") begin k1 = base; return 1; end
        if (sm != 0) begin k1 = base; k2 = sm; return 1; end
        return 0;
      end
      if (c0 == "t" && c1 == "s" && c2 == "u") begin k1 = 16'h3064; return 1; end
      if ((c0 == "x" || c0 == "l") && c1 == "t" && c2 == "u") begin
        k1 = CP_SMALL_TSU; return 1;
      end
      return 0;
    end
    if (len == 2) begin
      if (c0 == "n" && (c1 == "n" || c1 == "'")) begin k1 = CP_N; return 1; end
      if (c0 == "j") begin
        if (c1 == "i") begin k1 = 16'h3058; return 1; end
        if (small_y_of(c1) != 0) begin k1 = 16'h3058; k2 = small_y_of(c1); return 1; end
        return 0;
      end
      if (c0 >= "a" && c0 <= "z" && row_of(c0, vowel_of(c1)) != 0) begin
        k1 = row_of(c0, vowel_of(c1)); return 1;
      end
      return 0;
    end
    if (vowel_of(c0) >= 0) begin
      k1 = 16'h3042 + 16'(2 * vowel_of(c0)); return 1;
    end
    return 0;
  endfunction

  function automatic void push_kana(kind_t k, logic [15:0] code);
    out_item_t r;
    if (step_res.size() >= 8) return;
    r.kind = k; r.code = code; r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void drop_typed(int n);
    for (int i = 0; i + n < typed_cnt; i++) typed_buf[i] = typed_buf[i + n];
    typed_cnt -= n;
  endfunction

  // Works out every result that one accepted request causes.
  function automatic void predict_kana(in_item_t req);
    logic [15:0] k1, k2;
    bit hit;
    step_res.delete();
    case (action_t'(req.action))
      ACT_ADD: begin
        if (typed_cnt < 4) begin typed_buf[typed_cnt] = req.ch; typed_cnt++; end
        while (typed_cnt > 0) begin
          hit = 0;
          for (int len = (typed_cnt < 3 ? typed_cnt : 3); len >= 1; len--) begin
            if (!hit && match_kana(len, k1, k2)) begin
              push_kana(KIND_KANA, k1);
              if (k2 != 0) push_kana(KIND_KANA, k2);
              drop_typed(len);
              hit = 1;
            end
          end
          if (hit) continue;
          if (typed_cnt >= 2 && typed_buf[0] == typed_buf[1] && is_cons(typed_buf[0])
              && typed_buf[0] != CH_N) begin
            push_kana(KIND_KANA, CP_SMALL_TSU); drop_typed(1); continue;
          end
          if (typed_cnt >= 2 && typed_buf[0] == CH_N && vowel_of(typed_buf[1]) < 0
              && typed_buf[1] != "y" && typed_buf[1] != CH_N) begin
            push_kana(KIND_KANA, CP_N); drop_typed(1); continue;
          end
          if (typed_cnt >= 4) begin
            push_kana(KIND_RAW, {8'h0, typed_buf[0]}); drop_typed(1); continue;
          end
          break;
        end
      end
      ACT_FLUSH: begin
        if (typed_cnt == 1 && typed_buf[0] == CH_N) push_kana(KIND_KANA, CP_N);
        else for (int i = 0; i < typed_cnt; i++) push_kana(KIND_RAW, {8'h0, typed_buf[i]});
        typed_cnt = 0;
      end
      ACT_BKSP: begin
        if (typed_cnt > 0) typed_cnt--;
        else push_kana(KIND_ERASE_LAST, 16'h0);
      end
      default: begin
        typed_cnt = 0;
        push_kana(KIND_ERASE_ALL, 16'h0);
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) kana_q.push_back(step_res[i]);
  endfunction

  // Driver: bursts of requests with random gaps between them.
  int burst_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_kana(in_data);
      if (request_q.size() > 0 && burst_left > 0) begin
        in_data <= request_q.pop_front();
        in_valid <= 1'b1;
        burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 3) == 0) burst_left <= $urandom_range(1, 12);
      end
    end
  end

  // Receiver stall pattern: long free runs alternate with stretches of random stalling.
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 64;
      if (stall_phase < 24) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // Monitor: each result taken is compared with the oldest expectation.
  out_item_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (kana_q.size() == 0) begin
        $error("unexpected result kind=%0d code=%h last=%0d",
               out_data.kind, out_data.code, out_data.last);
        failed = 1;
      end else begin
        want = kana_q.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind); failed = 1;
        end
        if (out_data.code !== want.code) begin
          $error("code: expected %h, got %h", want.code, out_data.code); failed = 1;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last); failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void add_req(action_t a, logic [7:0] c);
    in_item_t r;
    r.action = a; r.ch = c;
    request_q.push_back(r);
  endfunction

  function automatic void add_word(string s);
    for (int i = 0; i < s.len(); i++) add_req(ACT_ADD, s[i]);
  endfunction

  // Letters that make up well-formed syllables, plus a few troublemakers.
  string syllables[] = '{"ka", "shi", "tsu", "nya", "kya", "ji", "jo", "n'", "nn", "kko",
                         "xtu", "ltu", "xya", "cha", "fu", "wo", "a", "i", "u", "e", "o",
                         "nk", "tte", "byu", "chi", "ryo"};
  initial begin
    int n;
    string s;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    failed = 0;
    cycle_cnt = 0;
    typed_cnt = 0;
    burst_left = 0;
    // Directed: extremes of the byte, each action, and the special cases.
    add_req(ACT_BKSP, 8'h00);            // backspace with nothing pending
    add_req(ACT_CLEAR, 8'hFF);
    add_word("kya");
    add_word("n"); add_req(ACT_FLUSH, 8'h00);      // lone n flushes as kana
    add_req(ACT_FLUSH, 8'h00);                     // empty flush gives nothing
    add_req(ACT_ADD, 8'h00); add_req(ACT_ADD, 8'hFF);
    add_req(ACT_ADD, "Q"); add_req(ACT_ADD, 8'h80); // fourth byte passes one raw
    add_req(ACT_FLUSH, 8'h00);
    add_word("kk"); add_req(ACT_BKSP, 8'h00); add_word("a");
    add_word("nk"); add_word("a");
    add_word("xq"); add_req(ACT_CLEAR, 8'h00);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Random: mostly well-formed syllables, the rest random bytes and actions.
    while (request_q.size() < 420) begin
      n = $urandom_range(0, 9);
      if (n < 6) begin
        s = syllables[$urandom_range(0, syllables.size() - 1)];
        add_word(s);
      end else if (n < 8) begin
        add_req(ACT_ADD, 8'($urandom_range(0, 255)));
      end else begin
        add_req(action_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
      end
    end
    add_req(ACT_FLUSH, 8'h00);
    stim_done = 1;
  end

  // End of run: all requests taken and every expected result seen.
  initial begin
    stim_done = 0;
    wait (stim_done);
    wait (request_q.size() == 0 && !in_valid && kana_q.size() == 0);
    repeat (64) @(posedge clk);
    if (!failed && kana_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/r2k_pkg.sv
sv/r2k_rule_unit.sv
sv/romaji_to_kana_transliterator.sv
tb/sv/romaji_to_kana_transliterator_tb.sv
